// ===== rtl/accel_gesture_rep_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gesture repetition counter
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ACCEL_GESTURE_REP_COUNTER_DEFINES_SVH
`define ACCEL_GESTURE_REP_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AGRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AGRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/agrc_pkg.sv =====
// ----------------------------------------------------------------------------
// agrc_pkg
// Types, constants and conversion functions for the gesture repetition counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package agrc_pkg;

  // Default number of strokes that make one repetition.
  localparam int STROKES_PER_REP_DEF = 4;

  // Reset values of the threshold registers.
  localparam logic [7:0] LOW_THR_RST  = 8'd20;
  localparam logic [7:0] HIGH_THR_RST = 8'd80;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;

  // Axis indices into pose vectors.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Milli-g weight of bits 0 to 6 of the absolute axis value.
  localparam logic [9:0] AXIS_WEIGHT [7] = '{10'd16, 10'd31, 10'd63, 10'd125,
                                              10'd250, 10'd500, 10'd1000};

  // Reciprocal of ten in 19 fractional bits, exact for sums below 43690.
  localparam logic [15:0] RECIP10 = 16'd52429;

  // Configuration register indices.
  typedef enum logic [1:0] {
    CFG_PATTERN  = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_HIGH_THR = 2'd2
  } cfg_index_t;

  // Gesture patterns.
  typedef enum logic [1:0] {
    PAT_NONE = 2'd0,
    PAT_Y_Z  = 2'd1,
    PAT_X_Z  = 2'd2,
    PAT_X_Y  = 2'd3
  } pattern_t;

  // A configuration write as seen by the front and the back.
  typedef struct packed {
    logic       en;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [7:0] level_x;
    logic [7:0] level_y;
    logic [7:0] level_z;
    logic [2:0] pose;
  } q_item_t;

  // Weighted milli-g sum of one raw axis byte.
  function automatic logic [10:0] axis_sum(input logic [7:0] raw);
    logic [7:0]  mag;
    logic [10:0] sum;
    mag = raw[7] ? (~raw + 8'd1) : raw;
    sum = '0;
    for (int i = 0; i < 7; i++) begin
      if (mag[i]) begin
        sum = sum + 11'(AXIS_WEIGHT[i]);
      end
    end
    return sum;
  endfunction

  // Division of a weighted sum by ten through the reciprocal.
  function automatic logic [7:0] div10(input logic [10:0] sum);
    logic [26:0] prod;
    prod = 27'(sum) * 27'(RECIP10);
    return prod[26:19];
  endfunction

endpackage

// ===== rtl/accel_gesture_rep_counter.sv =====
// ----------------------------------------------------------------------------
// accel_gesture_rep_counter
// Path: an accepted sample passes the front stage register, a queue entry and
// the result register. Throughput: one item per cycle while out_tready is high;
// the front stage, the two-entry queue and the output register each hand on an
// item per cycle, so the rate is set by the stroke update in the back.
// Reset: rst_n low at a clock edge clears all items in flight, the counters and
// the expected pose, and sets pattern 0, low threshold 20, high threshold 80.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_gesture_rep_counter
  import agrc_pkg::*;
#(
  parameter int STROKES_PER_REP = STROKES_PER_REP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // Sample input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_x[7:0], raw_y[15:8], raw_z[23:16]
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // level_x[7:0], level_y[15:8], level_z[23:16],
                                  // stroke_accepted[24], rep_done[25],
                                  // strokes_now[29:26], reps_now[37:30], zero[39:38]
);

  cfg_wr_t cfg_wr;
  logic    push_valid, push_ready;
  q_item_t push_item;
  logic    pop_valid, pop_ready;
  q_item_t pop_item;

  // Configuration write bundle for both halves.
  assign cfg_wr = '{en: cfg_wr_en, index: cfg_addr, data: cfg_wdata};

  agrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  agrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  agrc_back #(
    .STROKES_PER_REP (STROKES_PER_REP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== rtl/agrc_front.sv =====
// ----------------------------------------------------------------------------
// agrc_front
// Accepts samples, converts the axes to levels and classifies the poses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agrc_front
  import agrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_data,
  output logic        push_valid,
  input  logic        push_ready,
  output q_item_t     push_item
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [10:0] sum_x_r, sum_y_r, sum_z_r;
  logic [7:0]  low_thr_r, low_thr_nxt;
  logic [7:0]  high_thr_r, high_thr_nxt;
  logic [7:0]  lvl_x, lvl_y, lvl_z;
  logic [2:0]  active, quiet;
  logic        take;

  // The stage takes a new item when empty or when its item moves on.
  assign in_ready   = !s1_valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = s1_valid_r;

  always_comb begin
    s1_valid_nxt = take ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);
  end

  // Threshold registers.
  always_comb begin
    low_thr_nxt  = low_thr_r;
    high_thr_nxt = high_thr_r;
    if (cfg_wr.en) begin
      case (cfg_wr.index)
        CFG_LOW_THR:  low_thr_nxt  = cfg_wr.data;
        CFG_HIGH_THR: high_thr_nxt = cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      low_thr_r  <= LOW_THR_RST;
      high_thr_r <= HIGH_THR_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      low_thr_r  <= low_thr_nxt;
      high_thr_r <= high_thr_nxt;
    end
  end

  // Weighted sums are registered on acceptance.
  always_ff @(posedge clk) begin
    if (take) begin
      sum_x_r <= axis_sum(in_data[7:0]);
      sum_y_r <= axis_sum(in_data[15:8]);
      sum_z_r <= axis_sum(in_data[23:16]);
    end
  end

  // Levels and pose classification of the staged item.
  always_comb begin
    lvl_x  = div10(sum_x_r);
    lvl_y  = div10(sum_y_r);
    lvl_z  = div10(sum_z_r);
    active = {lvl_z > high_thr_r, lvl_y > high_thr_r, lvl_x > high_thr_r};
    quiet  = {lvl_z < low_thr_r, lvl_y < low_thr_r, lvl_x < low_thr_r};
    push_item.level_x = lvl_x;
    push_item.level_y = lvl_y;
    push_item.level_z = lvl_z;
    push_item.pose[AXIS_X] = active[AXIS_X] && quiet[AXIS_Y] && quiet[AXIS_Z];
    push_item.pose[AXIS_Y] = active[AXIS_Y] && quiet[AXIS_X] && quiet[AXIS_Z];
    push_item.pose[AXIS_Z] = active[AXIS_Z] && quiet[AXIS_X] && quiet[AXIS_Y];
  end

endmodule

// ===== rtl/agrc_queue.sv =====
// ----------------------------------------------------------------------------
// agrc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agrc_queue
  import agrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  q_item_t       mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/agrc_back.sv =====
// ----------------------------------------------------------------------------
// agrc_back
// Matches poses against the pattern, counts strokes and repetitions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "accel_gesture_rep_counter_defines.svh"

module agrc_back
  import agrc_pkg::*;
#(
  parameter int STROKES_PER_REP = STROKES_PER_REP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  q_item_t     pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_data
);

  localparam logic [3:0] STROKES_LIM = 4'(STROKES_PER_REP);

  pattern_t    pattern_r, pattern_nxt;
  logic        expect_r, expect_nxt;
  logic [3:0]  stroke_r, stroke_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_lx_r, out_ly_r, out_lz_r;
  logic        out_acc_r, out_done_r;
  logic [3:0]  out_strokes_r;
  logic [7:0]  out_reps_r;
  logic        pop;
  logic [1:0]  first_axis, second_axis, target;
  logic        hit, wrap;
  logic [3:0]  stroke_inc;

  // An item leaves the queue when the output register is free or drains.
  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = {2'b00, out_reps_r, out_strokes_r, out_done_r, out_acc_r,
                      out_lz_r, out_ly_r, out_lx_r};

  // Pose expected next under the selected pattern.
  always_comb begin
    case (pattern_r)
      PAT_Y_Z: begin
        first_axis  = AXIS_Y;
        second_axis = AXIS_Z;
      end
      PAT_X_Z: begin
        first_axis  = AXIS_X;
        second_axis = AXIS_Z;
      end
      PAT_X_Y: begin
        first_axis  = AXIS_X;
        second_axis = AXIS_Y;
      end
      default: begin
        first_axis  = AXIS_X;
        second_axis = AXIS_X;
      end
    endcase
    target     = expect_r ? second_axis : first_axis;
    hit        = (pattern_r != PAT_NONE) && pop_item.pose[target];
    stroke_inc = stroke_r + 4'd1;
    wrap       = (stroke_inc >= STROKES_LIM);
  end

  // Stroke and repetition state; a pattern write clears the strokes and expected pose, not the repetitions.
  always_comb begin
    pattern_nxt = pattern_r;
    expect_nxt  = expect_r;
    stroke_nxt  = stroke_r;
    rep_nxt     = rep_r;
    if (cfg_wr.en && (cfg_wr.index == CFG_PATTERN)) begin
      pattern_nxt = pattern_t'(cfg_wr.data[1:0]);
      expect_nxt  = 1'b0;
      stroke_nxt  = '0;
    end else if (pop && hit) begin
      expect_nxt = !expect_r;
      stroke_nxt = wrap ? 4'd0 : stroke_inc;
      rep_nxt    = wrap ? rep_r + 8'd1 : rep_r;
    end
    out_valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= PAT_NONE;
      expect_r    <= 1'b0;
      stroke_r    <= '0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pattern_r   <= pattern_nxt;
      expect_r    <= expect_nxt;
      stroke_r    <= stroke_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register, loaded as an item leaves the queue.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_lx_r      <= pop_item.level_x;
      out_ly_r      <= pop_item.level_y;
      out_lz_r      <= pop_item.level_z;
      out_acc_r     <= hit;
      out_done_r    <= hit && wrap;
      out_strokes_r <= stroke_nxt;
      out_reps_r    <= rep_nxt;
    end
  end

  // The stroke count never reaches the repetition length.
  `AGRC_ASSERT_IMP(a_stroke_below_lim, out_valid_r, out_strokes_r < STROKES_LIM, "stroke count overrun")

  // A finished repetition is an accepted stroke that restarts the count.
  `AGRC_ASSERT_IMP(a_done_restarts, out_valid_r && out_done_r, out_acc_r && (out_strokes_r == 4'd0), "repetition without restart")

  // Each matched pose flips the expected pose.
  `AGRC_ASSERT_NXT(a_expect_toggles, pop && hit && !cfg_wr.en, expect_r != $past(expect_r), "expectation did not toggle")

  // Without a match the repetition count holds.
  `AGRC_ASSERT_NXT(a_rep_holds, pop && !hit && !cfg_wr.en, $stable(rep_r), "repetition count moved without a stroke")

endmodule
